// ===== rtl/core/lru_buffer_cache_refcount_macros.svh =====
// Assertion macros used by the buffer cache directory back end.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef LRU_BUFFER_CACHE_REFCOUNT_MACROS_SVH
`define LRU_BUFFER_CACHE_REFCOUNT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LBC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbc assertion failed");

// antecedent implies consequent in the next cycle
`define LBC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbc assertion failed");

`endif

// ===== rtl/core/lbc_pkg.sv =====
// Package for the buffer cache directory: request and status codes,
// field widths and the queued word type. No dependencies.
package lbc_pkg;

   localparam int DEFAULT_BUFFERS = 32;
   localparam int SLOT_W  = 5;
   localparam int DEV_W   = 8;
   localparam int BLOCK_W = 32;
   localparam int COUNT_W = 8;
   localparam int STATUS_W = 3;

   // request codes
   localparam logic [1:0] REQ_GET     = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_PIN     = 2'd2;
   localparam logic [1:0] REQ_UNPIN   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNDER  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVER   = 3'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // one classified request word
   typedef struct packed {
      logic [1:0]         op;
      logic [DEV_W-1:0]   dev;
      logic [BLOCK_W-1:0] blk;
      logic [SLOT_W-1:0]  slot;
      logic               in_range;
   } item_type;

endpackage

// ===== rtl/core/lbc_front.sv =====
// Front end: accepts request words, checks the slot range and queues them.
// Depends on lbc_pkg.
module lbc_front #(
   parameter int BUFFERS = lbc_pkg::DEFAULT_BUFFERS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [lbc_pkg::DEV_W-1:0]   req_dev,
   input  logic [lbc_pkg::BLOCK_W-1:0] req_blockno,
   input  logic [lbc_pkg::SLOT_W-1:0]  req_slot,
   input  logic                        pop,
   output logic                        head_valid,
   output lbc_pkg::item_type           head
);

   lbc_pkg::item_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   lbc_pkg::item_type word;

   // classify incoming word
   always_comb begin
      word.op       = req_type;
      word.dev      = req_dev;
      word.blk      = req_blockno;
      word.slot     = req_slot;
      word.in_range = (int'(req_slot) < BUFFERS);
   end

   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;
   assign head_valid = (fill_ff != 2'd0);
   assign head       = ent_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== rtl/core/lbc_back.sv =====
// Back end: directory state, slot scan for get, count and LRU updates.
// Depends on lbc_pkg and lru_buffer_cache_refcount_macros.svh.
`include "lru_buffer_cache_refcount_macros.svh"

module lbc_back #(
   parameter int BUFFERS = lbc_pkg::DEFAULT_BUFFERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  lbc_pkg::item_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [lbc_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [lbc_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_needs_read
);

   localparam int IW = $clog2(BUFFERS);
   localparam int TW = lbc_pkg::DEV_W + lbc_pkg::BLOCK_W;
   localparam logic [IW-1:0] LAST = IW'(BUFFERS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_EXEC   = 3'd4;

   logic [2:0] state_ff, state_in;
   lbc_pkg::item_type cur_ff;
   logic [IW-1:0] cnt_ff, cnt_in;

   // directory state
   logic [TW-1:0]                tag_mem_ff [BUFFERS];
   logic [TW-1:0]                tag_q_ff;
   logic [BUFFERS-1:0]           tw_ff;
   logic [lbc_pkg::COUNT_W-1:0]  count_ff [BUFFERS];
   logic [BUFFERS-1:0]           valid_ff;
   logic [IW-1:0]                rank_ff [BUFFERS];

   // scan pipeline stage
   logic                         p_vld_ff;
   logic [IW-1:0]                p_idx_ff, p_rank_ff;
   logic [lbc_pkg::COUNT_W-1:0]  p_cnt_ff;
   logic                         p_valid_ff, p_tw_ff;

   // best hit (highest rank) and best free slot (lowest rank)
   logic                         hit_f_ff, free_f_ff;
   logic [IW-1:0]                hit_idx_ff, hit_rank_ff, free_idx_ff, free_rank_ff;
   logic [lbc_pkg::COUNT_W-1:0]  hit_cnt_ff;
   logic                         hit_valid_ff;

   logic [IW-1:0]                rd_idx, op_idx;
   logic [lbc_pkg::COUNT_W-1:0]  rd_cnt;
   logic [TW-1:0]                tag_seen;
   logic                         match, take_hit, take_free;

   logic                         rsp_valid_ff;
   logic [lbc_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [lbc_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         rsp_read_ff;

   assign op_idx = IW'(cur_ff.slot);
   assign rd_idx = (state_ff == S_SCAN) ? cnt_ff : op_idx;
   assign rd_cnt = count_ff[rd_idx];
   assign pop    = (state_ff == S_IDLE) && head_valid;

   // tag compare on the registered memory word
   assign tag_seen  = p_tw_ff ? tag_q_ff : '0;
   assign match     = p_vld_ff && (tag_seen == {cur_ff.dev, cur_ff.blk});
   assign take_hit  = match && (!hit_f_ff || (p_rank_ff > hit_rank_ff));
   assign take_free = p_vld_ff && (p_cnt_ff == '0)
                      && (!free_f_ff || (p_rank_ff < free_rank_ff));

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (head_valid) begin
               state_in = (head.op == lbc_pkg::REQ_GET) ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            if (cnt_ff == LAST) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN:  state_in = S_DECIDE;
         S_DECIDE: state_in = S_IDLE;
         S_EXEC:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         p_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         p_vld_ff <= (state_ff == S_SCAN);
      end
   end

   // tag memory, registered read
   always_ff @(posedge clock) begin
      tag_q_ff <= tag_mem_ff[cnt_ff];
      if (state_ff == S_DECIDE && !hit_f_ff && free_f_ff) begin
         tag_mem_ff[free_idx_ff] <= {cur_ff.dev, cur_ff.blk};
      end
   end

   // scan stage and candidate tracking
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      p_idx_ff   <= cnt_ff;
      p_rank_ff  <= rank_ff[cnt_ff];
      p_cnt_ff   <= rd_cnt;
      p_valid_ff <= valid_ff[cnt_ff];
      p_tw_ff    <= tw_ff[cnt_ff];
      if (state_ff == S_IDLE) begin
         hit_f_ff  <= 1'b0;
         free_f_ff <= 1'b0;
      end else begin
         if (take_hit) begin
            hit_f_ff     <= 1'b1;
            hit_idx_ff   <= p_idx_ff;
            hit_rank_ff  <= p_rank_ff;
            hit_cnt_ff   <= p_cnt_ff;
            hit_valid_ff <= p_valid_ff;
         end
         if (take_free) begin
            free_f_ff    <= 1'b1;
            free_idx_ff  <= p_idx_ff;
            free_rank_ff <= p_rank_ff;
         end
      end
   end

   // counts, valid marks, ranks and response
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff        <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUFFERS; i++) begin
            count_ff[i] <= '0;
            rank_ff[i]  <= IW'(i);
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (state_ff == S_DECIDE) begin
            rsp_valid_ff <= 1'b1;
            if (hit_f_ff) begin
               rsp_slot_ff <= lbc_pkg::SLOT_W'(hit_idx_ff);
               if (hit_cnt_ff == lbc_pkg::COUNT_MAX) begin
                  rsp_status_ff <= lbc_pkg::ST_OVER;
                  rsp_read_ff   <= 1'b0;
               end else begin
                  count_ff[hit_idx_ff] <= hit_cnt_ff + 1'b1;
                  valid_ff[hit_idx_ff] <= 1'b1;
                  rsp_status_ff        <= lbc_pkg::ST_HIT;
                  rsp_read_ff          <= !hit_valid_ff;
               end
            end else if (free_f_ff) begin
               count_ff[free_idx_ff] <= lbc_pkg::COUNT_W'(1);
               valid_ff[free_idx_ff] <= 1'b1;
               tw_ff[free_idx_ff]    <= 1'b1;
               rsp_slot_ff   <= lbc_pkg::SLOT_W'(free_idx_ff);
               rsp_status_ff <= lbc_pkg::ST_MISS;
               rsp_read_ff   <= 1'b1;
            end else begin
               rsp_slot_ff   <= '0;
               rsp_status_ff <= lbc_pkg::ST_NOFREE;
               rsp_read_ff   <= 1'b0;
            end
         end else if (state_ff == S_EXEC) begin
            rsp_valid_ff <= 1'b1;
            rsp_slot_ff  <= cur_ff.slot;
            rsp_read_ff  <= 1'b0;
            if (!cur_ff.in_range) begin
               rsp_status_ff <= lbc_pkg::ST_OK;
            end else if (cur_ff.op == lbc_pkg::REQ_PIN) begin
               if (rd_cnt == lbc_pkg::COUNT_MAX) begin
                  rsp_status_ff <= lbc_pkg::ST_OVER;
               end else begin
                  count_ff[op_idx] <= rd_cnt + 1'b1;
                  rsp_status_ff    <= lbc_pkg::ST_OK;
               end
            end else if (rd_cnt == '0) begin
               rsp_status_ff <= lbc_pkg::ST_UNDER;
            end else begin
               count_ff[op_idx] <= rd_cnt - 1'b1;
               rsp_status_ff    <= lbc_pkg::ST_OK;
               // release to zero: move slot to most recent
               if (cur_ff.op == lbc_pkg::REQ_RELEASE
                   && rd_cnt == lbc_pkg::COUNT_W'(1)) begin
                  for (int i = 0; i < BUFFERS; i++) begin
                     if (rank_ff[i] > rank_ff[op_idx]) begin
                        rank_ff[i] <= rank_ff[i] - 1'b1;
                     end
                  end
                  rank_ff[op_idx] <= LAST;
               end
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_needs_read = rsp_read_ff;

   `LBC_ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff)
   `LBC_ASSERT_IMPL(a_pop_idle, pop, state_ff == S_IDLE)
   `LBC_ASSERT_NEXT(a_decide_strobes, state_ff == S_DECIDE || state_ff == S_EXEC, rsp_valid_ff)
   `LBC_ASSERT_IMPL(a_scan_get, state_ff == S_SCAN, cur_ff.op == lbc_pkg::REQ_GET)

endmodule

// ===== rtl/core/lru_buffer_cache_refcount.sv =====
// Top level of the buffer cache directory: front queue and back engine.
// Depends on lbc_pkg, lbc_front and lbc_back.
//
// Usage:
//   A request word (req_type, req_dev, req_blockno, req_slot) is taken at a
//   rising edge with start high and busy low. Requests queue in a two-entry
//   buffer; busy rises while it is full.
//   Each request yields one result word on rsp_slot_out, rsp_status and
//   rsp_needs_read, shown for exactly one cycle with rsp_valid high. The
//   receiver cannot stall; results are always taken.
//   Get walks every slot once through the tag memory read port, tracking
//   the most recent hit and the least recent free slot in the same pass;
//   release, pin and unpin skip the walk. The back end handles one request
//   at a time, so a get holds off the requests queued behind it.
//   Reset empties the queue, clears counts, valid marks and tags to zero
//   and sets slot i to recency rank i; no clearing pass is needed.
module lru_buffer_cache_refcount #(
   parameter int BUFFERS = lbc_pkg::DEFAULT_BUFFERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [lbc_pkg::DEV_W-1:0]     req_dev,
   input  logic [lbc_pkg::BLOCK_W-1:0]   req_blockno,
   input  logic [lbc_pkg::SLOT_W-1:0]    req_slot,
   output logic                          rsp_valid,
   output logic [lbc_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [lbc_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_needs_read
);

   logic              pop, head_valid;
   lbc_pkg::item_type head;

   lbc_front #(.BUFFERS(BUFFERS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_dev     (req_dev),
      .req_blockno (req_blockno),
      .req_slot    (req_slot),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   lbc_back #(.BUFFERS(BUFFERS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_status     (rsp_status),
      .rsp_needs_read (rsp_needs_read)
   );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the buffer cache directory lru_buffer_cache_refcount.
// Depends on lbc_pkg and the RTL top level; holds its own directory model.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBUF = lbc_pkg::DEFAULT_BUFFERS;
   localparam int IDLE_LIMIT = 2000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_type = lbc_pkg::REQ_GET;
   logic [lbc_pkg::DEV_W-1:0]    req_dev = '0;
   logic [lbc_pkg::BLOCK_W-1:0]  req_blockno = '0;
   logic [lbc_pkg::SLOT_W-1:0]   req_slot = '0;
   logic                         rsp_valid;
   logic [lbc_pkg::SLOT_W-1:0]   rsp_slot_out;
   logic [lbc_pkg::STATUS_W-1:0] rsp_status;
   logic                         rsp_needs_read;

   lru_buffer_cache_refcount #(.BUFFERS(NBUF)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_dev(req_dev), .req_blockno(req_blockno),
      .req_slot(req_slot), .rsp_valid(rsp_valid), .rsp_slot_out(rsp_slot_out),
      .rsp_status(rsp_status), .rsp_needs_read(rsp_needs_read)
   );

   typedef struct packed {
      logic [lbc_pkg::SLOT_W-1:0]   slot_out;
      logic [lbc_pkg::STATUS_W-1:0] status;
      logic                         needs_read;
   } dir_result_type;

   // directory model state
   logic [lbc_pkg::DEV_W-1:0]   m_dev   [NBUF];
   logic [lbc_pkg::BLOCK_W-1:0] m_blk   [NBUF];
   logic [lbc_pkg::COUNT_W-1:0] m_count [NBUF];
   logic                        m_valid [NBUF];
   int                          m_rank  [NBUF];

   dir_result_type pending_results[$];
   int errors = 0;
   int idle_cycles = 0;
   logic [lbc_pkg::SLOT_W-1:0] held_slots[$];

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   function automatic int slot_at_rank(input int r);
      for (int i = 0; i < NBUF; i++) if (m_rank[i] == r) return i;
      return 0;
   endfunction

   // predict one request and update the model
   function automatic dir_result_type predict_dir(
      input logic [1:0] op,
      input logic [lbc_pkg::DEV_W-1:0] d,
      input logic [lbc_pkg::BLOCK_W-1:0] b,
      input logic [lbc_pkg::SLOT_W-1:0] s);
      dir_result_type res;
      int k, rk;
      res = '{slot_out: s, status: lbc_pkg::ST_OK, needs_read: 1'b0};
      if (op == lbc_pkg::REQ_GET) begin
         for (int r = NBUF - 1; r >= 0; r--) begin
            k = slot_at_rank(r);
            if (m_dev[k] == d && m_blk[k] == b) begin
               res.slot_out = k[lbc_pkg::SLOT_W-1:0];
               if (m_count[k] == lbc_pkg::COUNT_MAX) begin
                  res.status = lbc_pkg::ST_OVER;
               end else begin
                  m_count[k]++;
                  res.status = lbc_pkg::ST_HIT;
                  res.needs_read = !m_valid[k];
                  m_valid[k] = 1'b1;
               end
               return res;
            end
         end
         for (int r = 0; r < NBUF; r++) begin
            k = slot_at_rank(r);
            if (m_count[k] == 0) begin
               m_dev[k] = d;
               m_blk[k] = b;
               m_count[k] = lbc_pkg::COUNT_W'(1);
               m_valid[k] = 1'b1;
               return '{slot_out: k[lbc_pkg::SLOT_W-1:0], status: lbc_pkg::ST_MISS,
                        needs_read: 1'b1};
            end
         end
         return '{slot_out: '0, status: lbc_pkg::ST_NOFREE, needs_read: 1'b0};
      end
      if (s >= NBUF) return res;
      if (op == lbc_pkg::REQ_PIN) begin
         if (m_count[s] == lbc_pkg::COUNT_MAX) res.status = lbc_pkg::ST_OVER;
         else m_count[s]++;
         return res;
      end
      if (m_count[s] == 0) begin
         res.status = lbc_pkg::ST_UNDER;
         return res;
      end
      m_count[s]--;
      if (op == lbc_pkg::REQ_RELEASE && m_count[s] == 0) begin
         rk = m_rank[s];
         for (int i = 0; i < NBUF; i++) if (m_rank[i] > rk) m_rank[i]--;
         m_rank[s] = NBUF - 1;
      end
      return res;
   endfunction

   // send one word, predicting its result when it is taken; start stays high
   task automatic send_word(input logic [1:0] op, input logic [lbc_pkg::DEV_W-1:0] d,
                            input logic [lbc_pkg::BLOCK_W-1:0] b,
                            input logic [lbc_pkg::SLOT_W-1:0] s);
      req_type <= op;
      req_dev <= d;
      req_blockno <= b;
      req_slot <= s;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_dir(op, d, b, s));
      if (op == lbc_pkg::REQ_GET
          && pending_results[$].status inside {lbc_pkg::ST_HIT, lbc_pkg::ST_MISS})
         held_slots.push_back(pending_results[$].slot_out);
   endtask

   // random burst gap: short or none most of the time
   task automatic sender_gap();
      int g;
      if ($urandom_range(3) != 0) return;
      g = $urandom_range(12);
      if (g == 0) return;
      start <= 1'b0;
      repeat (g) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      dir_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_slot_out !== want.slot_out)
               report_mismatch($sformatf("slot_out %0d want %0d", rsp_slot_out, want.slot_out));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d want %0d", rsp_status, want.status));
            if (rsp_needs_read !== want.needs_read)
               report_mismatch($sformatf("needs_read %0b want %0b", rsp_needs_read,
                                         want.needs_read));
         end
      end
   end

   // watchdog on cycles with no accepted word and no result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("** lru_buffer_cache_refcount: FAILED **");
         $finish;
      end
   end

   task automatic test_reset_tags();
      // every slot starts tagged (0,0), so this hits and asks for a read
      send_word(lbc_pkg::REQ_GET, '0, '0, '0);
      send_word(lbc_pkg::REQ_GET, '0, '0, '0);
      send_word(lbc_pkg::REQ_GET, 8'hFF, 32'hFFFF_FFFF, '0);
      send_word(lbc_pkg::REQ_RELEASE, '0, '0, 5'd31);
   endtask

   task automatic test_slot_ops();
      send_word(lbc_pkg::REQ_UNPIN, '0, '0, 5'd5);
      send_word(lbc_pkg::REQ_RELEASE, '0, '0, 5'd6);
      send_word(lbc_pkg::REQ_PIN, '0, '0, 5'd7);
      send_word(lbc_pkg::REQ_UNPIN, '0, '0, 5'd7);
      send_word(lbc_pkg::REQ_PIN, '0, '0, 5'd0);
      send_word(lbc_pkg::REQ_RELEASE, '0, '0, 5'd0);
      send_word(lbc_pkg::REQ_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      send_word(lbc_pkg::REQ_RELEASE, '0, '0, 5'd31);
   endtask

   task automatic test_overflow();
      // drive one count to its ceiling, then hit it by get and pin
      for (int i = 0; i < 256; i++) send_word(lbc_pkg::REQ_PIN, '0, '0, 5'd9);
      send_word(lbc_pkg::REQ_GET, m_dev[9], m_blk[9], '0);
      for (int i = 0; i < 255; i++) send_word(lbc_pkg::REQ_RELEASE, '0, '0, 5'd9);
      send_word(lbc_pkg::REQ_RELEASE, '0, '0, 5'd9);
   endtask

   task automatic test_no_free();
      // hold every slot, then get a new block with no free slot left
      for (int i = 0; i < NBUF; i++)
         send_word(lbc_pkg::REQ_GET, 8'h40, lbc_pkg::BLOCK_W'(i), '0);
      send_word(lbc_pkg::REQ_GET, 8'h41, 32'h1234_5678, '0);
      for (int i = 0; i < NBUF; i++)
         send_word(lbc_pkg::REQ_RELEASE, '0, '0, i[lbc_pkg::SLOT_W-1:0]);
      held_slots.delete();
   endtask

   task automatic test_random(input int n);
      int pick, idx;
      logic [lbc_pkg::DEV_W-1:0] d;
      logic [lbc_pkg::BLOCK_W-1:0] b;
      for (int i = 0; i < n; i++) begin
         sender_gap();
         pick = $urandom_range(99);
         d = lbc_pkg::DEV_W'($urandom_range(3));
         b = lbc_pkg::BLOCK_W'($urandom_range(47));
         if (pick < 5) begin
            d = lbc_pkg::DEV_W'($urandom);
            b = lbc_pkg::BLOCK_W'($urandom);
         end
         if (pick < 45) begin
            send_word(lbc_pkg::REQ_GET, d, b, lbc_pkg::SLOT_W'($urandom));
         end else if (pick < 80 && held_slots.size() > 0) begin
            idx = $urandom_range(held_slots.size() - 1);
            send_word(lbc_pkg::REQ_RELEASE, lbc_pkg::DEV_W'($urandom),
                      lbc_pkg::BLOCK_W'($urandom), held_slots[idx]);
            held_slots.delete(idx);
         end else if (pick < 88) begin
            send_word(lbc_pkg::REQ_PIN, lbc_pkg::DEV_W'($urandom),
                      lbc_pkg::BLOCK_W'($urandom), lbc_pkg::SLOT_W'($urandom));
         end else begin
            send_word(2'($urandom_range(1, 3)), lbc_pkg::DEV_W'($urandom),
                      lbc_pkg::BLOCK_W'($urandom), lbc_pkg::SLOT_W'($urandom));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NBUF; i++) begin
         m_dev[i] = '0;
         m_blk[i] = '0;
         m_count[i] = '0;
         m_valid[i] = 1'b0;
         m_rank[i] = i;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_tags();
      test_slot_ops();
      test_no_free();
      test_overflow();
      test_random(800);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (NBUF + 20) @(posedge clock);
      if (errors == 0) $display("** lru_buffer_cache_refcount: PASSED **");
      else $display("** lru_buffer_cache_refcount: FAILED **");
      $finish;
   end
endmodule
